### rtl/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_pkg
// Shared constants, types and byte functions for the AES encrypt pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int RoundKeyWords = 60;
    localparam int MaxRounds     = 14;
    localparam int RkIdxW        = $clog2(RoundKeyWords);

    typedef enum logic [2:0] {
        REG_KEY_SIZE = 3'd0,
        REG_KEY_A    = 3'd1,
        REG_KEY_B    = 3'd2,
        REG_KEY_C    = 3'd3,
        REG_KEY_D    = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } key_size_t;

    typedef logic [127:0] block_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // state byte n (fips order) sits at bits [127-8n -: 8]
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (4 * c + r) -: 8] =
                    sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t t);
        block_t s;
        logic [7:0] a0, a1, a2, a3;
        for (int c = 0; c < 4; c++) begin
            a0 = t[127 - 32 * c -: 8];
            a1 = t[119 - 32 * c -: 8];
            a2 = t[111 - 32 * c -: 8];
            a3 = t[103 - 32 * c -: 8];
            s[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            s[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            s[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            s[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### rtl/aes_key_expand.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_round_key_gen
// Expands the configured key one word per cycle into round-key registers.
// ----------------------------------------------------------------------------
module aes_round_key_gen (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [1:0]   key_size,
    input  wire logic [255:0] key,
    output logic [3:0]        round_count,
    output aes_pkg::block_t   round_keys [aes_pkg::MaxRounds + 1]
);
    import aes_pkg::*;

    localparam int CntW = $clog2(RoundKeyWords + 1);

    block_t          rk_reg [MaxRounds + 1];
    logic [31:0]     win_reg [8];
    logic [CntW-1:0] idx_reg;
    logic [CntW-1:0] total_reg;
    logic [3:0]      nk_reg;
    logic [2:0]      pos_reg;
    logic [7:0]      rc_reg;
    logic            busy_reg;
    logic [3:0]      rounds_reg;

    logic [3:0]      nk_next;
    logic [31:0]     prev_w;
    logic [31:0]     old_w;
    logic [31:0]     w_next;
    logic [31:0]     key_w [8];
    logic [31:0]     win_init [8];

    // win_reg[j] holds the word j+1 places behind the one being built
    always_comb begin
        for (int i = 0; i < 8; i++) key_w[i] = key[255 - 32 * i -: 32];
        case (key_size)
            KEY_128: nk_next = 4'd4;
            KEY_192: nk_next = 4'd6;
            default: nk_next = 4'd8;
        endcase
        if (nk_next > 4'd4 && 4 * (int'(nk_next) + 7) > RoundKeyWords) nk_next = 4'd6;
        if (nk_next > 4'd4 && 4 * (int'(nk_next) + 7) > RoundKeyWords) nk_next = 4'd4;
        for (int j = 0; j < 8; j++) win_init[j] = '0;
        case (nk_next)
            4'd4: begin
                for (int j = 0; j < 4; j++) win_init[j] = key_w[3 - j];
            end
            4'd6: begin
                for (int j = 0; j < 6; j++) win_init[j] = key_w[5 - j];
            end
            default: begin
                for (int j = 0; j < 8; j++) win_init[j] = key_w[7 - j];
            end
        endcase
        prev_w = win_reg[0];
        case (nk_reg)
            4'd4:    old_w = win_reg[3];
            4'd6:    old_w = win_reg[5];
            default: old_w = win_reg[7];
        endcase
        if (pos_reg == 3'd0) begin
            w_next = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rc_reg, 24'd0};
        end else if (nk_reg > 4'd6 && pos_reg == 3'd4) begin
            w_next = sub_word(prev_w);
        end else begin
            w_next = prev_w;
        end
        w_next = w_next ^ old_w;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            rounds_reg <= 4'd10;
            idx_reg    <= '0;
            total_reg  <= '0;
            nk_reg     <= 4'd4;
            pos_reg    <= '0;
            rc_reg     <= 8'h01;
        end else if (start) begin
            rk_reg[0]  <= key[255:128];
            rk_reg[1]  <= key[127:0];
            for (int j = 0; j < 8; j++) win_reg[j] <= win_init[j];
            nk_reg     <= nk_next;
            rounds_reg <= nk_next + 4'd6;
            total_reg  <= CntW'(4 * (int'(nk_next) + 7));
            idx_reg    <= CntW'(nk_next);
            pos_reg    <= '0;
            rc_reg     <= 8'h01;
            busy_reg   <= 1'b1;
        end else if (busy_reg) begin
            if (idx_reg < total_reg) begin
                rk_reg[idx_reg[CntW-1:2]][{~idx_reg[1:0], 5'b0} +: 32] <= w_next;
                win_reg[0] <= w_next;
                for (int j = 1; j < 8; j++) win_reg[j] <= win_reg[j-1];
                idx_reg <= idx_reg + CntW'(1);
                if (pos_reg + 3'd1 == nk_reg[2:0] || (nk_reg == 4'd8 && pos_reg == 3'd7)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 3'd1;
                end
                if (pos_reg == 3'd0) rc_reg <= xtime(rc_reg);
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign round_count = rounds_reg;

    always_comb begin
        for (int r = 0; r <= MaxRounds; r++) begin
            round_keys[r] = rk_reg[r];
        end
    end

endmodule
`default_nettype wire

### rtl/aes_block_encrypt_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_encrypt_top
// Fully unrolled AES encrypt pipeline for 128/192/256-bit keys.
// ----------------------------------------------------------------------------
// usage:
//   configuration: write key_size and key words on cfg_*; each write to an
//   index up to four restarts the key schedule, one word per cycle; the round
//   keys are complete once the schedule has run through its words; write only
//   with nothing in flight and send data after
//   s_axis: one plaintext block per transaction, plain_high in tdata[63:0] and
//   plain_low in tdata[127:64], each big-endian
//   m_axis: one ciphertext block per transaction in the same layout
//   pipeline: 16 register stages (initial key add, fourteen rounds always
//   traversed with rounds past the last passing the state unchanged, output
//   register); throughput: one block per cycle while the output is not
//   stalled, set by the one-round-per-stage pipeline
//   stall: with the output full and m_axis_tready low the whole pipeline holds;
//   s_axis_tready falls only when the output stage is full and not being drained
//   reset: pipeline empties, key size returns to 128 bits with 10 rounds;
//   round keys are undefined until a key is written
// ----------------------------------------------------------------------------
module aes_block_encrypt_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // plain_high, plain_low
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata    // cipher_high, cipher_low
);
    import aes_pkg::*;

    localparam int Stages = MaxRounds + 1;

    logic [1:0]   key_size_reg;
    logic [255:0] key_reg;
    logic         start_reg;
    logic [3:0]   round_count;
    block_t       round_keys [MaxRounds + 1];

    block_t       st_reg    [Stages];
    logic         vld_reg   [Stages];
    block_t       out_reg;
    logic         out_vld_reg;
    logic         adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_size_reg <= KEY_128;
            key_reg      <= '0;
            start_reg    <= 1'b0;
        end else begin
            start_reg <= cfg_wr_en && (cfg_index <= REG_KEY_D);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_KEY_SIZE: key_size_reg <= cfg_wdata[1:0];
                    REG_KEY_A:    key_reg[255:192] <= cfg_wdata;
                    REG_KEY_B:    key_reg[191:128] <= cfg_wdata;
                    REG_KEY_C:    key_reg[127:64] <= cfg_wdata;
                    REG_KEY_D:    key_reg[63:0] <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    aes_round_key_gen u_key (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (start_reg),
        .key_size    (key_size_reg),
        .key         (key_reg),
        .round_count (round_count),
        .round_keys  (round_keys)
    );

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_reg[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ round_keys[0];
            for (int r = 1; r < Stages; r++) begin
                if (r < int'(round_count)) begin
                    st_reg[r] <= mix_columns(sub_shift(st_reg[r-1])) ^ round_keys[r];
                end else if (r == int'(round_count)) begin
                    st_reg[r] <= sub_shift(st_reg[r-1]) ^ round_keys[r];
                end else begin
                    st_reg[r] <= st_reg[r-1];
                end
            end
            out_reg <= st_reg[Stages-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < Stages; r++) vld_reg[r] <= 1'b0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= s_axis_tvalid;
            for (int r = 1; r < Stages; r++) vld_reg[r] <= vld_reg[r-1];
            out_vld_reg <= vld_reg[Stages-1];
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_reg[63:0], out_reg[127:64]};

endmodule
`default_nettype wire

### rtl/aes_block_encrypt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aes_block_encrypt_checker
// Port-level checks on the encrypt pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module aes_block_encrypt_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind aes_block_encrypt_top aes_block_encrypt_checker u_checker (.*);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the AES encrypt pipeline against its own cipher and key schedule:
// known-answer blocks for all three key sizes first, then random keys and
// random blocks under bursty input traffic and output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
    import aes_pkg::*;

    localparam logic [2:0] REG_SPARE  = 3'd7;
    localparam int         PIPE_DRAIN = 24;
    localparam int         SCHED_WAIT = 72;
    localparam int         WDOG_LIMIT = 20000;
    localparam int         RAND_ITEMS = 1250;

    localparam logic [7:0] SB [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

    typedef struct {
        bit           is_cfg;
        logic [2:0]   idx;
        logic [63:0]  wdata;
        logic [127:0] plain;
        bit           known;
        logic [127:0] cipher;
    } stim_row_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;

    logic [1:0]   key_len;
    logic [63:0]  key_words [4];
    logic [31:0]  sched [60];
    int           n_rounds;
    logic [127:0] cipher_q [$];
    stim_row_t    rows [$];
    int           n_errors;
    int           idle_cycles;
    int           burst_left;
    int           stall_left;
    int           run_left;

    aes_block_encrypt_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // plain_high, plain_low
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // cipher_high, cipher_low
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {SB[w[31:24]], SB[w[23:16]], SB[w[15:8]], SB[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        int         nk;
        int         total;
        logic [7:0] rcon;
        logic [31:0] w;
        nk = (key_len == 2'd3) ? 8 : 4 + 2 * key_len;
        n_rounds = nk + 6;
        total = 4 * (n_rounds + 1);
        rcon = 8'h01;
        for (int i = 0; i < nk; i++) begin
            sched[i] = i[0] ? key_words[i / 2][31:0] : key_words[i / 2][63:32];
        end
        for (int i = nk; i < total; i++) begin
            w = sched[i - 1];
            if (i % nk == 0) begin
                w = sbox_word({w[23:0], w[31:24]}) ^ {rcon, 24'h0};
                rcon = dbl(rcon);
            end else if (nk > 6 && i % nk == 4) begin
                w = sbox_word(w);
            end
            sched[i] = sched[i - nk] ^ w;
        end
    endfunction

    function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
        logic [7:0] st [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        for (int n = 0; n < 16; n++) st[n] = plain[127 - 8 * n -: 8];
        for (int r = 0; r <= n_rounds; r++) begin
            if (r > 0) begin
                for (int c = 0; c < 4; c++)
                    for (int i = 0; i < 4; i++)
                        t[4 * c + i] = SB[st[4 * ((c + i) % 4) + i]];
                for (int c = 0; c < 4; c++) begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    if (r < n_rounds) begin
                        st[4 * c]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                        st[4 * c + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                        st[4 * c + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                        st[4 * c + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                    end else begin
                        st[4 * c] = a0; st[4 * c + 1] = a1;
                        st[4 * c + 2] = a2; st[4 * c + 3] = a3;
                    end
                end
            end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    st[4 * c + i] ^= sched[4 * r + c][31 - 8 * i -: 8];
        end
        for (int n = 0; n < 16; n++) res[127 - 8 * n -: 8] = st[n];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        n_errors++;
    endtask

    // waits until the pipeline has drained, then leaves it idle a while
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (cipher_q.size() > 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_KEY_SIZE: key_len = val[1:0];
            REG_KEY_A:    key_words[0] = val;
            REG_KEY_B:    key_words[1] = val;
            REG_KEY_C:    key_words[2] = val;
            REG_KEY_D:    key_words[3] = val;
            default: ;
        endcase
        if (idx <= REG_KEY_D) build_schedule();
    endtask

    task automatic end_config();
        cfg_wr_en <= 1'b0;
        repeat (SCHED_WAIT) @(posedge aclk);
    endtask

    task automatic send_block(input logic [127:0] plain, input bit known,
                              input logic [127:0] cipher);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {plain[63:0], plain[127:64]};
        do @(posedge aclk); while (!s_axis_tready);
        burst_left--;
        cipher_q.push_back(known ? cipher : encrypt_block(plain));
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] val);
        rows.push_back('{1'b1, idx, val, 128'h0, 1'b0, 128'h0});
    endfunction

    function automatic void add_blk(input logic [127:0] p, input bit k,
                                    input logic [127:0] c);
        rows.push_back('{1'b0, 3'd0, 64'h0, p, k, c});
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            run_left = 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (run_left > 0) begin
            m_axis_tready <= 1'b1;
            run_left--;
        end else begin
            m_axis_tready <= 1'b1;
            run_left = $urandom_range(0, 40);
            stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                      : $urandom_range(0, 2);
        end
    end

    logic [127:0] want;
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (cipher_q.size() == 0) begin
                $display("unexpected ciphertext %h at %0t", m_axis_tdata, $time);
                n_errors++;
            end else begin
                want = cipher_q.pop_front();
                if (m_axis_tdata[63:0] !== want[127:64])
                    report_mismatch("cipher_high", m_axis_tdata[63:0], want[127:64]);
                if (m_axis_tdata[127:64] !== want[63:0])
                    report_mismatch("cipher_low", m_axis_tdata[127:64], want[63:0]);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   sent;
        int   phase_len;
        bit   was_cfg;
        logic [63:0] ph_words [4];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        burst_left = 0;
        key_len = 2'd0;
        for (int i = 0; i < 4; i++) key_words[i] = '0;
        build_schedule();

        // known answers; unused key words carry junk to show they are ignored
        add_cfg(REG_KEY_C, 64'hffff_ffff_ffff_ffff);
        add_cfg(REG_KEY_D, 64'hffff_ffff_ffff_ffff);
        add_cfg(REG_KEY_SIZE, KEY_128);
        add_cfg(REG_KEY_A, 64'h0001_0203_0405_0607);
        add_cfg(REG_KEY_B, 64'h0809_0a0b_0c0d_0e0f);
        add_blk(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1,
                128'h69c4_e0d8_6a7b_0430_d8cd_b780_70b4_c55a);
        add_blk(128'h0, 1'b0, 128'h0);
        add_blk('1, 1'b0, 128'h0);
        add_cfg(REG_KEY_SIZE, KEY_192);
        add_cfg(REG_KEY_C, 64'h1011_1213_1415_1617);
        add_blk(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1,
                128'hdda9_7ca4_864c_dfe0_6eaf_70a0_ec0d_7191);
        add_cfg(REG_KEY_SIZE, KEY_256);
        add_cfg(REG_KEY_D, 64'h1819_1a1b_1c1d_1e1f);
        add_blk(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1,
                128'h8ea2_b7ca_5167_45bf_eafc_4990_4b49_6089);
        // key size three behaves as 256
        add_cfg(REG_KEY_SIZE, 64'h3);
        add_blk(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1,
                128'h8ea2_b7ca_5167_45bf_eafc_4990_4b49_6089);
        // spare register index changes nothing
        add_cfg(REG_SPARE, 64'hdead_beef_0bad_f00d);
        add_blk(128'h0011_2233_4455_6677_8899_aabb_ccdd_eeff, 1'b1,
                128'h8ea2_b7ca_5167_45bf_eafc_4990_4b49_6089);
        add_cfg(REG_KEY_A, '1);
        add_cfg(REG_KEY_B, '1);
        add_cfg(REG_KEY_C, '1);
        add_cfg(REG_KEY_D, '1);
        add_blk(128'h0, 1'b0, 128'h0);
        add_blk('1, 1'b0, 128'h0);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        was_cfg = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].is_cfg) begin
                if (!was_cfg) wait_idle();
                write_reg(rows[i].idx, rows[i].wdata);
                was_cfg = 1'b1;
            end else begin
                if (was_cfg) end_config();
                was_cfg = 1'b0;
                send_block(rows[i].plain, rows[i].known, rows[i].cipher);
            end
        end

        sent = 0;
        while (sent < RAND_ITEMS) begin
            wait_idle();
            for (int i = 0; i < 4; i++) ph_words[i] = rand64();
            write_reg(REG_KEY_SIZE, $urandom_range(0, 3));
            write_reg(REG_KEY_A, ph_words[0]);
            write_reg(REG_KEY_B, ph_words[1]);
            write_reg(REG_KEY_C, ph_words[2]);
            write_reg(REG_KEY_D, ph_words[3]);
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(5, 7)), rand64());
            end_config();
            phase_len = $urandom_range(60, 140);
            if (phase_len > RAND_ITEMS - sent) phase_len = RAND_ITEMS - sent;
            for (int k = 0; k < phase_len; k++) begin
                if (k == phase_len / 2 && $urandom_range(0, 2) == 0) wait_idle();
                send_block({rand64(), rand64()}, 1'b0, 128'h0);
            end
            sent += phase_len;
        end

        s_axis_tvalid <= 1'b0;
        while (cipher_q.size() > 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/aes_pkg.sv
rtl/aes_key_expand.sv
rtl/aes_block_encrypt_top.sv
rtl/aes_block_encrypt_checker.sv
dv/testbench.sv
